// ===== design/amgs_pkg.sv =====
package amgs_pkg;

  localparam int MODE_W  = 4;
  localparam int ID_W    = 4;
  localparam int COUNT_W = 5;
  localparam int TALLY_W = 9;
  localparam int MASK_W  = 16;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 5'd16;
  localparam logic [TALLY_W-1:0] TALLY_MAX      = 9'd511;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 4'd0,
    MODE_REMOVE   = 4'd1,
    MODE_TEST     = 4'd2,
    MODE_HAS_IN   = 4'd3,
    MODE_HAS_OUT  = 4'd4,
    MODE_POP      = 4'd5,
    MODE_DEGREE   = 4'd6,
    MODE_ARCS     = 4'd7,
    MODE_START    = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROW  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

endpackage

// ===== design/amgs_row_mem.sv =====
// Row store: one synchronous memory with a registered read, plus per-row
// valid flags cleared by reset. A row never written reads as all zero.
module amgs_row_mem #(
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DEPTH-1:0]  rd_row,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DEPTH-1:0]  wr_row
);

  logic [DEPTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] data_r;
  logic             data_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_row;
    end
    data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      data_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      data_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_row = data_vld_r ? data_r : '0;

endmodule

// ===== design/adjacency_matrix_graph_store_top.sv =====
// Channel     | Ports                                          | Handshake
// ------------+------------------------------------------------+-------------------------
// command     | start, busy, in_mode, in_from_node, in_to_node | taken when start & !busy
// result      | out_strobe, out_status, out_flag,              | one-cycle strobe,
//             | out_found_node, out_tally, out_start_mask      | no back-pressure
// config      | cfg_we, cfg_wdata (node_count)                 | written when cfg_we
//
// Answered from idle: an id error, an unused mode or a scan with no active nodes. Modes that
// touch one row (add, remove, test, has-outgoing, pop, degree) pass through ST_ROW; column
// scans (has-incoming, arc count, start mask) read n = min(node_count, MAX_NODES) rows in
// ST_SCAN: the single read port gives one row per cycle. Results and strobe are registered.
// Reset (rst_n low, synchronous) clears all rows through per-row valid flags, sets
// node_count to 16 and returns to idle. The receiver cannot stall; busy alone holds off start.
module adjacency_matrix_graph_store_top
  import amgs_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [ID_W-1:0]    in_from_node,
  input  logic [ID_W-1:0]    in_to_node,
  output logic               out_strobe,
  output logic               out_status,
  output logic               out_flag,
  output logic [ID_W-1:0]    out_found_node,
  output logic [TALLY_W-1:0] out_tally,
  output logic [MASK_W-1:0]  out_start_mask,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int ROW_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int TOT_W = $clog2(MAX_NODES * MAX_NODES + 1);
  localparam int ACC_W = (TOT_W > 10) ? TOT_W : 10;

  function automatic logic [CNT_W-1:0] pop_count(input logic [MAX_NODES-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

  // Control state
  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] node_count_r;
  logic               out_strobe_r, out_strobe_nxt;

  // Captured command and scan accumulators
  mode_t              mode_r, mode_nxt;
  logic [ID_W-1:0]    from_r, from_nxt;
  logic [ID_W-1:0]    to_r, to_nxt;
  logic [CNT_W-1:0]   rcv_idx_r, rcv_idx_nxt;
  logic               flag_acc_r, flag_acc_nxt;
  logic [ACC_W-1:0]   total_r, total_nxt;
  logic [MAX_NODES-1:0] hit_r, hit_nxt;

  // Result registers
  logic               out_status_r, out_status_nxt;
  logic               out_flag_r, out_flag_nxt;
  logic [ID_W-1:0]    out_found_r, out_found_nxt;
  logic [TALLY_W-1:0] out_tally_r, out_tally_nxt;
  logic [MASK_W-1:0]  out_mask_r, out_mask_nxt;

  // Memory port
  logic [ROW_W-1:0]     rd_addr;
  logic [MAX_NODES-1:0] rd_row;
  logic                 wr_en;
  logic [ROW_W-1:0]     wr_addr;
  logic [MAX_NODES-1:0] wr_row;

  // Active node count and column mask
  logic [CMP_W-1:0]     n_cmp;
  logic [CNT_W-1:0]     n;
  logic [MAX_NODES-1:0] cols;

  logic                 accept;
  mode_t                mode_in;
  logic                 from_bad;
  logic                 to_bad;
  logic [MAX_NODES-1:0] row_m;
  logic [MAX_NODES-1:0] to_bit;
  logic [ROW_W-1:0]     low_idx;

  assign n_cmp = (CMP_W'(node_count_r) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES)
                                                            : CMP_W'(node_count_r);
  assign n     = CNT_W'(n_cmp);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      cols[i] = (CMP_W'(i) < n_cmp);
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign mode_in  = mode_t'(in_mode);
  assign from_bad = !(CMP_W'(in_from_node) < n_cmp);
  assign to_bad   = !(CMP_W'(in_to_node) < n_cmp);

  // Row being modified or queried, masked to the active columns
  assign row_m  = rd_row & cols;
  assign to_bit = MAX_NODES'(1) << ROW_W'(to_r);

  // Lowest set column of the active row
  always_comb begin
    low_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (row_m[i]) begin
        low_idx = ROW_W'(i);
      end
    end
  end

  amgs_row_mem #(
    .DEPTH (MAX_NODES)
  ) u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    rcv_idx_nxt    = rcv_idx_r;
    flag_acc_nxt   = flag_acc_r;
    total_nxt      = total_r;
    hit_nxt        = hit_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_flag_nxt   = out_flag_r;
    out_found_nxt  = out_found_r;
    out_tally_nxt  = out_tally_r;
    out_mask_nxt   = out_mask_r;
    rd_addr        = ROW_W'(in_from_node);
    wr_en          = 1'b0;
    wr_addr        = ROW_W'(from_r);
    wr_row         = rd_row;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt     = mode_in;
          from_nxt     = in_from_node;
          to_nxt       = in_to_node;
          rcv_idx_nxt  = '0;
          flag_acc_nxt = 1'b0;
          total_nxt    = '0;
          hit_nxt      = '0;
          // Immediate result unless a memory pass is started below
          out_strobe_nxt = 1'b1;
          out_status_nxt = 1'b0;
          out_flag_nxt   = 1'b0;
          out_found_nxt  = '0;
          out_tally_nxt  = '0;
          out_mask_nxt   = '0;
          case (mode_in) inside
            MODE_ADD, MODE_REMOVE, MODE_TEST: begin
              if (from_bad || to_bad) begin
                out_status_nxt = 1'b1;
              end else begin
                out_strobe_nxt = 1'b0;
                state_nxt      = ST_ROW;
              end
            end
            MODE_HAS_OUT, MODE_POP, MODE_DEGREE: begin
              if (from_bad) begin
                out_status_nxt = 1'b1;
              end else begin
                out_strobe_nxt = 1'b0;
                state_nxt      = ST_ROW;
              end
            end
            MODE_HAS_IN: begin
              if (from_bad) begin
                out_status_nxt = 1'b1;
              end else begin
                out_strobe_nxt = 1'b0;
                rd_addr        = '0;
                state_nxt      = ST_SCAN;
              end
            end
            MODE_ARCS, MODE_START: begin
              // No active nodes: the all-zero result stands
              if (n != '0) begin
                out_strobe_nxt = 1'b0;
                rd_addr        = '0;
                state_nxt      = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_ROW: begin
        // Row of from_node is on rd_row: modify, write back, report
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
        unique case (mode_r)
          MODE_ADD: begin
            wr_en  = 1'b1;
            wr_row = rd_row | to_bit;
          end
          MODE_REMOVE: begin
            wr_en  = 1'b1;
            wr_row = rd_row & ~to_bit;
          end
          MODE_TEST: begin
            out_flag_nxt = |(rd_row & to_bit);
          end
          MODE_HAS_OUT: begin
            out_flag_nxt = |row_m;
          end
          MODE_POP: begin
            if (|row_m) begin
              wr_en         = 1'b1;
              wr_row        = rd_row & ~(MAX_NODES'(1) << low_idx);
              out_flag_nxt  = 1'b1;
              out_found_nxt = ID_W'(low_idx);
            end
          end
          MODE_DEGREE: begin
            out_tally_nxt = TALLY_W'(pop_count(row_m));
          end
          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        // Fold in row rcv_idx_r and fetch the next one
        flag_acc_nxt = flag_acc_r | rd_row[ROW_W'(from_r)];
        total_nxt    = total_r + ACC_W'(pop_count(row_m));
        hit_nxt      = hit_r | rd_row;
        rd_addr      = ROW_W'(rcv_idx_r + CNT_W'(1));
        if (rcv_idx_r == n - CNT_W'(1)) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
          if (mode_r == MODE_HAS_IN) begin
            out_flag_nxt = flag_acc_nxt;
          end
          if (mode_r == MODE_ARCS) begin
            out_tally_nxt = (total_nxt > ACC_W'(TALLY_MAX)) ? TALLY_MAX
                                                            : total_nxt[TALLY_W-1:0];
          end
          if (mode_r == MODE_START) begin
            out_mask_nxt = MASK_W'(cols & ~hit_nxt);
          end
        end else begin
          rcv_idx_nxt = rcv_idx_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      node_count_r <= NODE_COUNT_RST;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    rcv_idx_r    <= rcv_idx_nxt;
    flag_acc_r   <= flag_acc_nxt;
    total_r      <= total_nxt;
    hit_r        <= hit_nxt;
    out_status_r <= out_status_nxt;
    out_flag_r   <= out_flag_nxt;
    out_found_r  <= out_found_nxt;
    out_tally_r  <= out_tally_nxt;
    out_mask_r   <= out_mask_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_flag       = out_flag_r;
  assign out_found_node = out_found_r;
  assign out_tally      = out_tally_r;
  assign out_start_mask = out_mask_r;

endmodule

// ===== bench/graph_store_checker.sv =====
`timescale 1ns / 1ps

module graph_store_checker
  import amgs_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [ID_W-1:0]    in_from_node,
  input  logic [ID_W-1:0]    in_to_node,
  input  logic               out_strobe,
  input  logic               out_status,
  input  logic               out_flag,
  input  logic [ID_W-1:0]    out_found_node,
  input  logic [TALLY_W-1:0] out_tally,
  input  logic [MASK_W-1:0]  out_start_mask,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output int                 mismatches,
  output int                 pending
);

  typedef struct packed {
    logic               status;
    logic               flag;
    logic [ID_W-1:0]    found;
    logic [TALLY_W-1:0] tally;
    logic [MASK_W-1:0]  smask;
  } graph_reply_t;

  logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
  logic [COUNT_W-1:0]   node_count_q;
  graph_reply_t         expected_replies [$];
  int                   mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Apply one command to the shadow matrix and return the reply it should produce.
  function automatic graph_reply_t predict_graph_op(input logic [MODE_W-1:0] m,
                                                     input logic [ID_W-1:0] a,
                                                     input logic [ID_W-1:0] b);
    int                   n;
    int                   total;
    logic [MAX_NODES-1:0] cols;
    logic [MAX_NODES-1:0] row;
    logic [MAX_NODES-1:0] hit;
    bit                   got;
    graph_reply_t         r;
    n = (int'(node_count_q) > MAX_NODES) ? MAX_NODES : int'(node_count_q);
    for (int i = 0; i < MAX_NODES; i++) cols[i] = (i < n);
    r = '0;
    case (m)
      MODE_ADD, MODE_REMOVE, MODE_TEST: begin
        if (int'(a) >= n || int'(b) >= n) begin
          r.status = 1'b1;
        end else if (m == MODE_ADD) begin
          adj_rows[a][b] = 1'b1;
        end else if (m == MODE_REMOVE) begin
          adj_rows[a][b] = 1'b0;
        end else begin
          r.flag = adj_rows[a][b];
        end
      end
      MODE_HAS_IN, MODE_HAS_OUT, MODE_POP, MODE_DEGREE: begin
        row = adj_rows[a] & cols;
        if (int'(a) >= n) begin
          r.status = 1'b1;
        end else if (m == MODE_HAS_IN) begin
          for (int i = 0; i < n; i++) if (adj_rows[i][a]) r.flag = 1'b1;
        end else if (m == MODE_HAS_OUT) begin
          r.flag = |row;
        end else if (m == MODE_POP) begin
          got = 1'b0;
          for (int t = 0; t < MAX_NODES; t++) begin
            if (!got && row[t]) begin
              got = 1'b1;
              adj_rows[a][t] = 1'b0;
              r.flag = 1'b1;
              r.found = ID_W'(t);
            end
          end
        end else begin
          r.tally = TALLY_W'($countones(row));
        end
      end
      MODE_ARCS: begin
        total = 0;
        for (int i = 0; i < n; i++) total += $countones(adj_rows[i] & cols);
        r.tally = (total > int'(TALLY_MAX)) ? TALLY_MAX : TALLY_W'(total);
      end
      MODE_START: begin
        hit = '0;
        for (int i = 0; i < n; i++) hit |= adj_rows[i];
        r.smask = MASK_W'(cols & ~hit);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    graph_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) adj_rows[i] = '0;
      node_count_q = NODE_COUNT_RST;
      expected_replies.delete();
    end else begin
      if (out_strobe) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result strobe with no command outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0h, want %0h", out_status, want.status));
          if (out_flag !== want.flag)
            report_mismatch($sformatf("flag %0h, want %0h", out_flag, want.flag));
          if (out_found_node !== want.found)
            report_mismatch($sformatf("found_node %0h, want %0h", out_found_node, want.found));
          if (out_tally !== want.tally)
            report_mismatch($sformatf("tally %0h, want %0h", out_tally, want.tally));
          if (out_start_mask !== want.smask)
            report_mismatch($sformatf("start_mask %0h, want %0h", out_start_mask, want.smask));
        end
      end
      if (cfg_we) node_count_q = cfg_wdata;
      if (start && !busy)
        expected_replies.push_back(predict_graph_op(in_mode, in_from_node, in_to_node));
    end
    pending <= expected_replies.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import amgs_pkg::*;

  localparam int MAX_NODES  = 16;
  localparam int CYCLE_CAP  = 400000;
  // Drain pause: long enough for one full column scan and the result, with margin.
  localparam int DRAIN_WAIT = 24;
  // Mode codes the block does not define; it answers them with an all-zero reply.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [MODE_W-1:0]  in_mode        = '0;
  logic [ID_W-1:0]    in_from_node   = '0;
  logic [ID_W-1:0]    in_to_node     = '0;
  logic               out_strobe;
  logic               out_status;
  logic               out_flag;
  logic [ID_W-1:0]    out_found_node;
  logic [TALLY_W-1:0] out_tally;
  logic [MASK_W-1:0]  out_start_mask;
  logic               cfg_we         = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata      = '0;

  int mismatches;
  int pending;
  int cycle_count = 0;
  // Nodes currently in use, as the stimulus sees them; steers most ids into range.
  int live_nodes  = MAX_NODES;

  // Per-phase settings for the random part: node count, sender idle percentage, length.
  int phase_nodes [8] = '{16, 1, 31, 5, 0, 12, 2, 16};
  int phase_idle  [8] = '{0, 53, 30, 0, 53, 30, 0, 53};
  int phase_len   [8] = '{110, 60, 110, 100, 25, 100, 60, 110};

  always #6 clk = ~clk;

  adjacency_matrix_graph_store_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_flag       (out_flag),
    .out_found_node (out_found_node),
    .out_tally      (out_tally),
    .out_start_mask (out_start_mask),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  graph_store_checker #(.MAX_NODES(MAX_NODES)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_flag       (out_flag),
    .out_found_node (out_found_node),
    .out_tally      (out_tally),
    .out_start_mask (out_start_mask),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hold start low for a random number of cycles; pct is the chance of idling each cycle.
  task automatic idle_gap(input int pct);
    while (int'($urandom_range(99)) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Present one command and hold it until the block takes it (start high, busy low).
  // Start stays high on return so back-to-back transactions need no extra edge on it.
  task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] a,
                          input logic [ID_W-1:0] b, input int pct);
    idle_gap(pct);
    start        <= 1'b1;
    in_mode      <= m;
    in_from_node <= a;
    in_to_node   <= b;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every outstanding reply has come back and the block is idle.
  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Change node_count only with the block idle and nothing in flight.
  task automatic write_node_count(input logic [COUNT_W-1:0] value);
    drain_replies();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    live_nodes = (int'(value) > MAX_NODES) ? MAX_NODES : int'(value);
  endtask

  function automatic logic [ID_W-1:0] pick_node();
    if (live_nodes > 0 && $urandom_range(9) != 0)
      return ID_W'($urandom_range(live_nodes - 1, 0));
    return ID_W'($urandom_range(15, 0));
  endfunction

  function automatic logic [MODE_W-1:0] MODE_WIDTH_PICK();
    return MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
  endfunction

  // Random command, weighted toward edge edits and pops so the matrix fills and empties.
  task automatic send_random(input int pct);
    int                roll;
    logic [MODE_W-1:0] m;
    roll = $urandom_range(99);
    if (roll < 30)      m = MODE_ADD;
    else if (roll < 40) m = MODE_REMOVE;
    else if (roll < 50) m = MODE_TEST;
    else if (roll < 57) m = MODE_HAS_IN;
    else if (roll < 64) m = MODE_HAS_OUT;
    else if (roll < 76) m = MODE_POP;
    else if (roll < 83) m = MODE_DEGREE;
    else if (roll < 89) m = MODE_ARCS;
    else if (roll < 95) m = MODE_START;
    else                m = MODE_WIDTH_PICK();
    send_cmd(m, pick_node(), pick_node(), pct);
  endtask

  initial begin
    // Hold reset low at the start, then release it once for the whole run.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset node count: empty graph, edge edits, every query,
    // pop with and without an edge, a self loop, duplicate add, absent remove,
    // and the undefined modes.
    send_cmd(MODE_START,   4'd0,  4'd0,  0);
    send_cmd(MODE_ARCS,    4'd0,  4'd0,  0);
    send_cmd(MODE_ADD,     4'd0,  4'd15, 0);
    send_cmd(MODE_ADD,     4'd15, 4'd0,  0);
    send_cmd(MODE_ADD,     4'd3,  4'd3,  0);
    send_cmd(MODE_ADD,     4'd0,  4'd15, 0);
    send_cmd(MODE_TEST,    4'd0,  4'd15, 0);
    send_cmd(MODE_TEST,    4'd1,  4'd2,  0);
    send_cmd(MODE_HAS_IN,  4'd15, 4'd0,  0);
    send_cmd(MODE_HAS_IN,  4'd1,  4'd0,  0);
    send_cmd(MODE_HAS_OUT, 4'd2,  4'd0,  0);
    send_cmd(MODE_DEGREE,  4'd0,  4'd0,  0);
    send_cmd(MODE_ARCS,    4'd0,  4'd0,  0);
    send_cmd(MODE_START,   4'd0,  4'd0,  0);
    send_cmd(MODE_POP,     4'd0,  4'd0,  0);
    send_cmd(MODE_POP,     4'd0,  4'd0,  0);
    send_cmd(MODE_REMOVE,  4'd15, 4'd0,  0);
    send_cmd(MODE_REMOVE,  4'd5,  4'd6,  0);
    send_cmd(MODE_UNUSED_LO, 4'd15, 4'd15, 0);
    send_cmd(MODE_UNUSED_HI, 4'd0,  4'd0,  0);

    // Shrink to two nodes: the self loop on node 3 stays stored but hidden,
    // and ids at or above the count are errors.
    write_node_count(5'd2);
    send_cmd(MODE_ADD,     4'd1,  4'd2,  0);
    send_cmd(MODE_HAS_IN,  4'd3,  4'd0,  0);
    send_cmd(MODE_ARCS,    4'd0,  4'd0,  0);
    send_cmd(MODE_START,   4'd0,  4'd0,  0);

    // No nodes at all: every id is out of range, counts and mask come back empty.
    write_node_count(5'd0);
    send_cmd(MODE_ADD,     4'd0,  4'd0,  0);
    send_cmd(MODE_START,   4'd0,  4'd0,  0);

    // Random part: each phase sets a node count and an idle level, then runs
    // commands; an occasional full drain holds the sender until all replies are in.
    for (int p = 0; p < 8; p++) begin
      write_node_count(COUNT_W'(phase_nodes[p]));
      for (int k = 0; k < phase_len[p]; k++) begin
        send_random(phase_idle[p]);
        if ($urandom_range(49) == 0) drain_replies();
      end
    end

    // Let the last replies arrive, then give the verdict.
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
